/* hw/rtl/dsfp_pkg.sv */
// Shared types, constants and helper functions for the decimal string parser.
`default_nettype none

package dsfp_pkg;

    // Default sizing of the fixed-point result.
    localparam int WHOLE_BITS_DEF      = 31;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 4;

    // Widths of the stream payload fields.
    localparam int CHAR_W      = 8;
    localparam int VALUE_W     = 48;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 56;

    // Character codes that the parser recognises.
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

    // Position within the string, one-hot.
    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_SIGN  = 6'b000010,
        PH_WHOLE = 6'b000100,
        PH_POINT = 6'b001000,
        PH_FRAC  = 6'b010000,
        PH_BAD   = 6'b100000
    } t_phase;

    // Parser status handed to the sequencer.
    typedef struct packed {
        t_phase phase;
        logic   negative;
        logic   saturated;
    } t_parse_info;

    // Powers of ten for the fraction scaling divisor.
    function automatic logic [23:0] f_pow10(input logic [2:0] n);
        logic [23:0] p;
        unique case (n)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/decimal_string_to_fixed_point.sv */
// Top level of the decimal string to signed fixed-point converter.
//
//  Port group   Dir  Payload (lowest bit first)               Meaning
//  s_axis_*     in   tdata[7:0] char_code                     one string character
//  m_axis_*     out  tdata[47:0] value, [49:48] status        one result per terminator
//
// A character other than the terminator is taken as soon as it is offered. The
// terminator of a well-formed, unsaturated number waits in SQ_DIVIDE for the
// one-bit-per-cycle fraction divider; any other terminator goes straight to SQ_EMIT.
// s_axis_tready is low from the terminator until its result sits in the output
// register, and stays low while that register is full and not being taken.
// Reset is synchronous, active low, and returns the parser to the start of a string.
`default_nettype none

module decimal_string_to_fixed_point #(
    parameter int WHOLE_BITS      = dsfp_pkg::WHOLE_BITS_DEF,
    parameter int FRAC_BITS       = dsfp_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dsfp_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [dsfp_pkg::CHAR_W-1:0]        s_axis_tdata,   // [7:0] char_code
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [dsfp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // [47:0] value, [49:48] status
);
    import dsfp_pkg::*;

    localparam int FW     = $clog2(10**MAX_FRAC_DIGITS);
    localparam int FCNT_W = $clog2(MAX_FRAC_DIGITS+1);
    localparam int MAG_W  = WHOLE_BITS + FRAC_BITS;
    localparam int EXT_W  = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        SQ_ACCEPT = 3'b001,
        SQ_DIVIDE = 3'b010,
        SQ_EMIT   = 3'b100
    } t_seq_state;

    t_seq_state              r_state, n_state;
    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out_value;
    logic [STATUS_W-1:0]     r_out_status;

    t_parse_info             info;
    logic [WHOLE_BITS-1:0]   whole;
    logic [FW-1:0]           frac;
    logic [FCNT_W-1:0]       frac_count;
    logic                    div_busy;
    logic [FRAC_BITS-1:0]    quotient;

    logic                    in_xact;
    logic                    term_xact;
    logic                    numeric;
    logic                    out_free;
    logic                    load_out;
    logic                    div_start;
    logic [MAG_W-1:0]        mag;
    logic [EXT_W-1:0]        mag_ext;
    logic [EXT_W-1:0]        signed_ext;
    logic [VALUE_W-1:0]      n_value;
    logic [STATUS_W-1:0]     n_status;

    // Handshake decode.
    always_comb begin
        s_axis_tready = (r_state == SQ_ACCEPT);
        in_xact       = s_axis_tvalid && s_axis_tready;
        term_xact     = in_xact && (s_axis_tdata == CH_NUL);
        numeric       = (info.phase == PH_WHOLE) || (info.phase == PH_FRAC);
        div_start     = term_xact && numeric && !info.saturated;
        out_free      = !r_out_valid || m_axis_tready;
        load_out      = (r_state == SQ_EMIT) && out_free;
    end

    dsfp_parse #(
        .WHOLE_BITS      (WHOLE_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (in_xact),
        .i_char       (s_axis_tdata),
        .i_clear      (load_out),
        .o_info       (info),
        .o_whole      (whole),
        .o_frac       (frac),
        .o_frac_count (frac_count)
    );

    dsfp_div #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (frac),
        .i_count    (frac_count),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // Sequencer: accept characters, scale the fraction, then hand over the result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_ACCEPT: begin
                if (div_start) begin
                    n_state = SQ_DIVIDE;
                end else if (term_xact) begin
                    n_state = SQ_EMIT;
                end
            end
            SQ_DIVIDE: begin
                if (!div_busy) begin
                    n_state = SQ_EMIT;
                end
            end
            SQ_EMIT: begin
                if (out_free) begin
                    n_state = SQ_ACCEPT;
                end
            end
            default: begin
                n_state = SQ_ACCEPT;
            end
        endcase
    end

    // Result assembly: the quotient is below one, so it simply sits under the whole part.
    always_comb begin
        mag        = info.saturated ? {MAG_W{1'b1}} : {whole, quotient};
        mag_ext    = EXT_W'(mag);
        signed_ext = info.negative ? (EXT_W'(0) - mag_ext) : mag_ext;
        if (info.phase == PH_START) begin
            n_value  = '0;
            n_status = ST_OK;
        end else if (numeric) begin
            n_value  = signed_ext[VALUE_W-1:0];
            n_status = info.saturated ? ST_SATURATED : ST_OK;
        end else begin
            n_value  = '0;
            n_status = ST_MALFORMED;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value  <= n_value;
            r_out_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-VALUE_W-STATUS_W){1'b0}}, r_out_status, r_out_value};

endmodule

`default_nettype wire

/* hw/rtl/dsfp_parse.sv */
// Character parser: tracks the phase, the sign and the whole and fraction accumulators.
`default_nettype none

module dsfp_parse #(
    parameter int WHOLE_BITS      = dsfp_pkg::WHOLE_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dsfp_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          i_char_valid,
    input  wire  [dsfp_pkg::CHAR_W-1:0]                  i_char,
    input  wire                                          i_clear,
    output dsfp_pkg::t_parse_info                        o_info,
    output logic [WHOLE_BITS-1:0]                        o_whole,
    output logic [$clog2(10**MAX_FRAC_DIGITS)-1:0]       o_frac,
    output logic [$clog2(MAX_FRAC_DIGITS+1)-1:0]         o_frac_count
);
    import dsfp_pkg::*;

    localparam int FW     = $clog2(10**MAX_FRAC_DIGITS);
    localparam int FCNT_W = $clog2(MAX_FRAC_DIGITS+1);
    localparam int WX     = WHOLE_BITS + 4;
    localparam int FX     = FW + 4;

    t_phase              r_phase, n_phase;
    logic                r_negative, n_negative;
    logic                r_saturated, n_saturated;
    logic [WHOLE_BITS-1:0] r_whole, n_whole;
    logic [FW-1:0]       r_frac, n_frac;
    logic [FCNT_W-1:0]   r_frac_count, n_frac_count;

    logic                is_digit;
    logic [3:0]          digit;
    logic [WX-1:0]       whole_next;
    logic [WX-1:0]       whole_max;
    logic [FX-1:0]       frac_next;

    // Digit decode and the two multiply-by-ten accumulators.
    always_comb begin
        is_digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        digit      = 4'(i_char - CH_ZERO);
        whole_next = (WX'(r_whole) << 3) + (WX'(r_whole) << 1) + WX'(digit);
        whole_max  = WX'({WHOLE_BITS{1'b1}});
        frac_next  = (FX'(r_frac) << 3) + (FX'(r_frac) << 1) + FX'(digit);
    end

    // Phase transitions and accumulator updates for one character.
    always_comb begin
        n_phase      = r_phase;
        n_negative   = r_negative;
        n_saturated  = r_saturated;
        n_whole      = r_whole;
        n_frac       = r_frac;
        n_frac_count = r_frac_count;
        if (i_clear) begin
            n_phase      = PH_START;
            n_negative   = 1'b0;
            n_saturated  = 1'b0;
            n_whole      = '0;
            n_frac       = '0;
            n_frac_count = '0;
        end else if (i_char_valid && (i_char != CH_NUL)) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_char == CH_MINUS) begin
                        n_negative = 1'b1;
                        n_phase    = PH_SIGN;
                    end else if (is_digit) begin
                        n_phase = PH_WHOLE;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                PH_SIGN: begin
                    n_phase = is_digit ? PH_WHOLE : PH_BAD;
                end
                PH_WHOLE: begin
                    if (is_digit) begin
                        n_phase = PH_WHOLE;
                    end else if (i_char == CH_POINT) begin
                        n_phase = PH_POINT;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                PH_POINT, PH_FRAC: begin
                    if (is_digit) begin
                        n_phase = PH_FRAC;
                        if (r_frac_count < FCNT_W'(MAX_FRAC_DIGITS)) begin
                            n_frac       = frac_next[FW-1:0];
                            n_frac_count = r_frac_count + 1'b1;
                        end
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase

            // Whole-part digits saturate at the largest whole value.
            if (is_digit && ((r_phase == PH_START) || (r_phase == PH_SIGN) ||
                             (r_phase == PH_WHOLE))) begin
                if (r_saturated || (whole_next > whole_max)) begin
                    n_saturated = 1'b1;
                    n_whole     = {WHOLE_BITS{1'b1}};
                end else begin
                    n_whole = whole_next[WHOLE_BITS-1:0];
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_negative   <= 1'b0;
            r_saturated  <= 1'b0;
            r_whole      <= '0;
            r_frac       <= '0;
            r_frac_count <= '0;
        end else begin
            r_phase      <= n_phase;
            r_negative   <= n_negative;
            r_saturated  <= n_saturated;
            r_whole      <= n_whole;
            r_frac       <= n_frac;
            r_frac_count <= n_frac_count;
        end
    end

    assign o_info.phase     = r_phase;
    assign o_info.negative  = r_negative;
    assign o_info.saturated = r_saturated;
    assign o_whole          = r_whole;
    assign o_frac           = r_frac;
    assign o_frac_count     = r_frac_count;

endmodule

`default_nettype wire

/* hw/rtl/dsfp_div.sv */
// Restoring divider that scales the fraction digits to binary, one bit a cycle.
`default_nettype none

module dsfp_div #(
    parameter int FRAC_BITS       = dsfp_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dsfp_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    input  wire                                         i_start,
    input  wire  [$clog2(10**MAX_FRAC_DIGITS)-1:0]      i_dividend,
    input  wire  [$clog2(MAX_FRAC_DIGITS+1)-1:0]        i_count,
    output logic                                        o_busy,
    output logic [FRAC_BITS-1:0]                        o_quotient
);
    import dsfp_pkg::*;

    localparam int FW    = $clog2(10**MAX_FRAC_DIGITS);
    localparam int CNT_W = $clog2(FRAC_BITS+1);

    logic [FW-1:0]        r_rem;
    logic [FW-1:0]        r_div;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CNT_W-1:0]     r_cnt;

    logic [FW:0]          shifted;
    logic [FW:0]          diff;
    logic                 fits;

    // One trial subtraction of the divisor from the doubled remainder.
    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = shifted - {1'b0, r_div};
        fits    = (shifted >= {1'b0, r_div});
    end

    // Step counter: one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(FRAC_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Remainder and quotient; the dividend is always below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= FW'(f_pow10(3'(i_count)));
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[FW-1:0] : shifted[FW-1:0];
            r_quo <= {r_quo[FRAC_BITS-2:0], fits};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* hw/rtl/dsfp_checker.sv */
// Port-level checker for the converter, bound to the top level.
`default_nettype none

module dsfp_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire [dsfp_pkg::CHAR_W-1:0]         s_axis_tdata,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [dsfp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import dsfp_pkg::*;

    // A result held back by the consumer must not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // After a terminator the parser stops taking characters until its result is in the output register.
    a_term_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata == CH_NUL) |=> !s_axis_tready)
        else $error("input accepted straight after a terminator");

    // A malformed string always reports a zero value.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[49:48] == ST_MALFORMED) |-> m_axis_tdata[47:0] == '0)
        else $error("malformed result carries a non-zero value");

    // Only the three defined status codes appear, and the padding stays clear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[49:48] != 2'd3) && (m_axis_tdata[55:50] == '0))
        else $error("undefined status code or dirty padding");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result still valid after reset");

endmodule

bind decimal_string_to_fixed_point dsfp_checker u_dsfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* verif/decimal_string_to_fixed_point_test.sv */
// Self-checking testbench for the decimal string to fixed-point converter.
module decimal_string_to_fixed_point_test;

    import dsfp_pkg::*;

    localparam int WHOLE_W      = WHOLE_BITS_DEF;
    localparam int FRAC_W       = FRAC_BITS_DEF;
    localparam int FRAC_DIGITS  = MAX_FRAC_DIGITS_DEF;
    localparam int RANDOM_CHARS = 1070;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = FRAC_BITS_DEF + 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_GAP      = 13;

    // One converted number as it leaves the block.
    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } t_conv_result;

    // Tracks the parser state and holds the conversions still to arrive.
    class conv_scoreboard;
        t_phase       phase;
        bit           negative;
        logic [63:0]  whole_acc;
        logic [63:0]  frac_acc;
        int unsigned  frac_count;
        bit           saturated;
        t_conv_result expected_q[$];
        int           mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase      = PH_START;
            negative   = 1'b0;
            whole_acc  = '0;
            frac_acc   = '0;
            frac_count = 0;
            saturated  = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void fail_note(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: %s", what);
            end
        endfunction

        // The whole part sticks at its ceiling once it has overflowed.
        function void add_whole_digit(logic [3:0] d);
            logic [63:0] whole_max;
            logic [63:0] next;
            whole_max = (64'd1 << WHOLE_W) - 64'd1;
            next      = whole_acc * 64'd10 + 64'(d);
            if (saturated || next > whole_max) begin
                saturated = 1'b1;
                whole_acc = whole_max;
            end else begin
                whole_acc = next;
            end
        endfunction

        // Called for every character transaction the block accepts.
        function void note_char(logic [CHAR_W-1:0] c);
            bit           is_digit;
            logic [3:0]   d;
            logic [63:0]  mag;
            logic [63:0]  divisor;
            t_conv_result r;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            d        = 4'(c - CH_ZERO);

            // The terminator closes the string and yields one result.
            if (c == CH_NUL) begin
                r.value  = '0;
                r.status = ST_OK;
                case (phase)
                    PH_START: begin
                    end
                    PH_WHOLE, PH_FRAC: begin
                        if (saturated) begin
                            mag      = (64'd1 << (WHOLE_W + FRAC_W)) - 64'd1;
                            r.status = ST_SATURATED;
                        end else begin
                            divisor = 64'd1;
                            repeat (frac_count) divisor = divisor * 64'd10;
                            mag = (whole_acc << FRAC_W) + ((frac_acc << FRAC_W) / divisor);
                        end
                        if (negative) begin
                            mag = 64'd0 - mag;
                        end
                        r.value = mag[VALUE_W-1:0];
                    end
                    default: begin
                        r.status = ST_MALFORMED;
                    end
                endcase
                expected_q.push_back(r);
                clear();
                return;
            end

            // Any other character only moves the parser along.
            case (phase)
                PH_START: begin
                    if (c == CH_MINUS) begin
                        negative = 1'b1;
                        phase    = PH_SIGN;
                    end else if (is_digit) begin
                        add_whole_digit(d);
                        phase = PH_WHOLE;
                    end else begin
                        phase = PH_BAD;
                    end
                end
                PH_SIGN: begin
                    if (is_digit) begin
                        add_whole_digit(d);
                        phase = PH_WHOLE;
                    end else begin
                        phase = PH_BAD;
                    end
                end
                PH_WHOLE: begin
                    if (is_digit) begin
                        add_whole_digit(d);
                    end else if (c == CH_POINT) begin
                        phase = PH_POINT;
                    end else begin
                        phase = PH_BAD;
                    end
                end
                PH_POINT, PH_FRAC: begin
                    if (is_digit) begin
                        if (frac_count < FRAC_DIGITS) begin
                            frac_acc = frac_acc * 64'd10 + 64'(d);
                            frac_count++;
                        end
                        phase = PH_FRAC;
                    end else begin
                        phase = PH_BAD;
                    end
                end
                default: begin
                    phase = PH_BAD;
                end
            endcase
        endfunction

        // Compares one result transaction with the oldest conversion waiting.
        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            t_conv_result        want;
            logic [VALUE_W-1:0]  got_value;
            logic [STATUS_W-1:0] got_status;
            got_value  = tdata[VALUE_W-1:0];
            got_status = tdata[VALUE_W +: STATUS_W];
            if (expected_q.size() == 0) begin
                fail_note($sformatf("unexpected result: value %h status %0d",
                                    got_value, got_status));
                return;
            end
            want = expected_q.pop_front();
            if (got_value !== want.value || got_status !== want.status) begin
                fail_note($sformatf("expected value %h status %0d, got value %h status %0d",
                                    want.value, want.status, got_value, got_status));
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata  = '0;       // [7:0] char_code
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;             // [47:0] value, [49:48] status

    conv_scoreboard    sb = new();
    logic [CHAR_W-1:0] text_q[$];
    int                chars_accepted = 0;
    int                cycle_count    = 0;
    bit                sender_burst   = 1'b0;
    bit                long_hold_req  = 1'b0;

    decimal_string_to_fixed_point DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a period of eight time units.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the overall run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one character and waits for its transaction to complete.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_char(c);
        chars_accepted++;
    endtask

    // Sends the queued text followed by its terminator.
    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i]);
        send_char(CH_NUL);
        text_q.delete();
    endtask

    function automatic void load_text(string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic void push_digits(int count);
        repeat (count) text_q.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    endfunction

    // Drops valid and holds off until every conversion has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed numbers with random content; the rest noise or damaged.
    task automatic build_random_text();
        int    kind;
        int    sel;
        int    pos;
        string near_ceiling;
        near_ceiling = "214748364";
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(0, 5)) text_q.push_back(CHAR_W'($urandom_range(1, 255)));
            return;
        end
        if ($urandom_range(0, 1)) text_q.push_back(CH_MINUS);
        sel = $urandom_range(0, 9);
        if (sel == 9) begin
            // Right at the saturation threshold of the whole part.
            for (int i = 0; i < near_ceiling.len(); i++) text_q.push_back(near_ceiling[i]);
            push_digits($urandom_range(1, 2));
        end else if (sel == 8) begin
            push_digits($urandom_range(10, 13));
        end else begin
            push_digits($urandom_range(1, 6));
        end
        if ($urandom_range(0, 9) < 6) begin
            text_q.push_back(CH_POINT);
            push_digits($urandom_range(1, FRAC_DIGITS + 3));
        end
        if (kind >= 80) begin
            pos = $urandom_range(0, text_q.size());
            case ($urandom_range(0, 3))
                0: text_q.insert(pos, CHAR_W'($urandom_range(1, 255)));
                1: text_q.insert(pos, CH_MINUS);
                2: text_q.insert(pos, CH_POINT);
                default: while (text_q.size() > pos) void'(text_q.pop_back());
            endcase
        end
    endtask

    // Result side: random stalls, stall-free stretches and one long hold-off.
    initial begin
        int stall;
        int free_left;
        free_left = 0;
        wait (i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end else if (free_left > 0) begin
                free_left--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 15) == 0) free_left = 20;
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    // Reset, directed strings, random strings, then the final verdict.
    initial begin
        string directed_set[$];
        int    random_end;
        int    strings_sent;
        directed_set = '{"", "-", "1.", "-0.0", "2147483647.99999", "2147483648",
                         "-99999999999", "-3.14159", ".5", "--1", "1.2.3", "7a", "12-"};
        strings_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty, lone sign, trailing point, extremes, malformed.
        foreach (directed_set[i]) begin
            load_text(directed_set[i]);
            send_text();
        end
        text_q = '{CH_ZERO + CHAR_W'(3), 8'hFF};
        send_text();

        // Random part, with one long receiver hold-off and one full drain.
        random_end = chars_accepted + RANDOM_CHARS;
        while (chars_accepted < random_end) begin
            strings_sent++;
            if (strings_sent == 40) long_hold_req = 1'b1;
            if (strings_sent == 90) wait_drained();
            sender_burst = ($urandom_range(0, 3) == 0);
            build_random_text();
            send_text();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
